// File: hdl/anqh_pkg.sv
// Shared types, constants and the notch report table for the angle notch quantiser.
package anqh_pkg;

  localparam int ANGLE_W   = 12;
  localparam int BYTE_W    = 8;
  localparam int NOTCH_W   = 4;
  localparam int FRAC_W    = 4;
  localparam int SECT_BITS = 9;   // one sector of a 4095-count arc fits in 9 bits
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 12;
  localparam int DIV_STEPS = 12;
  localparam int CNT_W     = 4;
  localparam int RECIP_W   = 15;
  localparam int RECIP_SH  = 18;

  typedef logic [ANGLE_W-1:0]   angle_t;
  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [NOTCH_W-1:0]   notch_t;
  typedef logic [FRAC_W-1:0]    frac_t;
  typedef logic [SECT_BITS-1:0] sector_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_DAT_W-1:0] cfg_dat_t;

  // Register indexes of the configuration port.
  localparam cfg_idx_t REG_ARC_MIN     = 3'd0;
  localparam cfg_idx_t REG_ARC_MAX     = 3'd1;
  localparam cfg_idx_t REG_REVERSE_DIR = 3'd2;
  localparam cfg_idx_t REG_HYST_NUMER  = 3'd3;
  localparam cfg_idx_t REG_HYST_DENOM  = 3'd4;

  localparam angle_t RST_ARC_MIN    = 12'd200;
  localparam angle_t RST_ARC_MAX    = 12'd3900;
  localparam frac_t  RST_HYST_NUMER = 4'd1;
  localparam frac_t  RST_HYST_DENOM = 4'd3;

  localparam notch_t NOTCH_NEUTRAL = 4'd9;
  localparam notch_t NOTCH_TOP     = 4'd14;
  localparam angle_t SECTOR_COUNT  = 12'd15;

  // Reciprocal of fifteen scaled by 2^18; it gives the exact quotient for every 12-bit span.
  localparam logic [RECIP_W-1:0] SPAN_RECIP = 15'd17477;

  // Fixed report byte of each notch; the unused code reads as the neutral value.
  function automatic byte_t report_of(input notch_t n);
    byte_t r;
    unique case (n)
      4'd0:    r = 8'h00;
      4'd1:    r = 8'h05;
      4'd2:    r = 8'h13;
      4'd3:    r = 8'h20;
      4'd4:    r = 8'h2E;
      4'd5:    r = 8'h3C;
      4'd6:    r = 8'h49;
      4'd7:    r = 8'h57;
      4'd8:    r = 8'h65;
      4'd9:    r = 8'h80;
      4'd10:   r = 8'h9F;
      4'd11:   r = 8'hB7;
      4'd12:   r = 8'hCE;
      4'd13:   r = 8'hE6;
      4'd14:   r = 8'hFF;
      default: r = 8'h80;
    endcase
    return r;
  endfunction

endpackage

// File: hdl/anqh_if.sv
// Valid/ready channel interfaces for angle samples and notch results.
interface anqh_angle_if;
  import anqh_pkg::*;
  logic  valid;
  logic  ready;
  byte_t angle_high;
  byte_t angle_low;
  logic  bus_error;

  modport source (output valid, output angle_high, output angle_low, output bus_error,
                  input ready);
  modport sink   (input valid, input angle_high, input angle_low, input bus_error,
                  output ready);
endinterface

interface anqh_notch_if;
  import anqh_pkg::*;
  logic   valid;
  logic   ready;
  notch_t notch_index;
  byte_t  report_byte;

  modport source (output valid, output notch_index, output report_byte, input ready);
  modport sink   (input valid, input notch_index, input report_byte, output ready);
endinterface

// File: hdl/angle_notch_quantizer_hysteresis_core.sv
// Top level of the lever angle to notch quantiser with hysteresis.
//
// Each input transfer carries one sensor sample (a 12-bit angle from the low nibble of
// angle_high and all of angle_low, plus a bus error flag) and yields exactly one result
// transfer with the held notch and its fixed report byte. The angle is clamped to the
// configured arc, measured from its start and optionally mirrored; the arc is cut into
// 15 equal sectors and a new notch is taken only once the position lies a margin of
// hyst_numer/hyst_denom of a sector inside it. The sector width comes from one
// multiplication of the arc span by a fixed reciprocal of fifteen. The two remaining
// divisions (position by sector width, scaled width by the denominator) run one after
// another on a single restoring divider that retires one quotient bit per cycle. A normal
// sample passes through the sector width, the first division, the sector base and scaled
// width, the second division, the decision and the loading of the output register. The
// block is ready again in the cycle the result is offered. A zero denominator skips the
// second division. A sample with the bus error flag, or taken while the arc is degenerate
// (arc_max not above arc_min), skips all the arithmetic, a degenerate arc forcing the
// neutral notch, and goes straight to loading the output register; a narrow arc of fewer
// than 15 counts skips both divisions and the scaling. The block takes one
// sample at a time; it accepts the next sample while an earlier result still waits to
// be taken, and only holds off the finish of that sample until the output register is
// free. Configuration registers are written through cfg_we, cfg_index and cfg_wdata,
// and must only be changed while no sample is in flight.
module angle_notch_quantizer_hysteresis_core (
  input  logic                clk,
  input  logic                rst_n,
  anqh_angle_if.sink          in_chan,
  anqh_notch_if.source        out_chan,
  input  logic                cfg_we,
  input  anqh_pkg::cfg_idx_t  cfg_index,
  input  anqh_pkg::cfg_dat_t  cfg_wdata
);
  import anqh_pkg::*;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_WIDTH  = 3'd1;  // sector width = span / 15 by reciprocal
  localparam logic [2:0] ST_DIVI   = 3'd2;  // nominal notch = position / width
  localparam logic [2:0] ST_PROD   = 3'd3;  // sector base and scaled width
  localparam logic [2:0] ST_DIVM   = 3'd4;  // margin = width * numer / denom
  localparam logic [2:0] ST_DECIDE = 3'd5;
  localparam logic [2:0] ST_FINISH = 3'd6;

  logic [2:0] state_r, state_nxt;

  // Configuration registers.
  angle_t arc_min_r, arc_min_nxt;
  angle_t arc_max_r, arc_max_nxt;
  logic   rev_r, rev_nxt;
  frac_t  numer_r, numer_nxt;
  frac_t  denom_r, denom_nxt;

  notch_t held_r, held_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Working registers of one sample.
  angle_t  pos_r, pos_nxt;
  sector_t w_r, w_nxt;
  notch_t  idx_r, idx_nxt;
  angle_t  lo_r, lo_nxt;
  angle_t  marg_r, marg_nxt;
  notch_t  out_notch_r, out_notch_nxt;
  byte_t   out_report_r, out_report_nxt;

  // Shared divider: quotient register doubles as the dividend shift register.
  logic [ANGLE_W:0] rem_r, rem_nxt;
  angle_t           quo_r, quo_nxt;
  angle_t           div_r, div_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [ANGLE_W:0]   rem_sh;
  logic [ANGLE_W+1:0] diff;
  logic               ge;
  logic [ANGLE_W:0]   rem_step;
  angle_t             quo_step;
  logic               div_last;

  // Front end of a new sample.
  angle_t raw;
  angle_t raw_c;
  angle_t span;
  angle_t pos_fwd;
  angle_t pos_new;
  logic   arc_bad;

  // Sector width from the span.
  logic [ANGLE_W+RECIP_W-1:0] w_prod;
  sector_t                    w_new;

  // Products and decision terms.
  logic [ANGLE_W:0] lo_full;
  logic [ANGLE_W:0] wn_full;
  logic [ANGLE_W:0] hi_sum;
  logic [ANGLE_W:0] lo_marg;
  logic [ANGLE_W:0] pos_marg;

  logic in_xfer;
  logic out_xfer;

  assign in_chan.ready      = (state_r == ST_IDLE);
  assign in_xfer            = in_chan.valid && in_chan.ready;
  assign out_chan.valid     = out_valid_r;
  assign out_chan.notch_index = out_notch_r;
  assign out_chan.report_byte = out_report_r;
  assign out_xfer           = out_valid_r && out_chan.ready;

  // One restoring division step: bring in the next dividend bit, subtract if it fits.
  always_comb begin
    rem_sh   = {rem_r[ANGLE_W-1:0], quo_r[ANGLE_W-1]};
    diff     = {1'b0, rem_sh} - {2'b00, div_r};
    ge       = ~diff[ANGLE_W+1];
    rem_step = ge ? diff[ANGLE_W:0] : rem_sh;
    quo_step = {quo_r[ANGLE_W-2:0], ge};
    div_last = (cnt_r == CNT_W'(DIV_STEPS - 1));
  end

  // Clamp the raw angle to the arc and turn it into a position from the arc start.
  always_comb begin
    raw     = {in_chan.angle_high[3:0], in_chan.angle_low};
    arc_bad = (arc_max_r <= arc_min_r);
    span    = arc_max_r - arc_min_r;
    if (raw < arc_min_r) begin
      raw_c = arc_min_r;
    end else if (raw > arc_max_r) begin
      raw_c = arc_max_r;
    end else begin
      raw_c = raw;
    end
    pos_fwd = raw_c - arc_min_r;
    pos_new = rev_r ? (span - pos_fwd) : pos_fwd;
  end

  // The span only changes with the registers, so the width is ready once a sample is in.
  always_comb begin
    w_prod = (ANGLE_W+RECIP_W)'(span) * (ANGLE_W+RECIP_W)'(SPAN_RECIP);
    w_new  = w_prod[RECIP_SH +: SECT_BITS];
  end

  // Sector base, scaled width and the hysteresis comparisons; all fit in 13 bits.
  always_comb begin
    lo_full  = (ANGLE_W+1)'(idx_r) * (ANGLE_W+1)'(w_r);
    wn_full  = (ANGLE_W+1)'(w_r) * (ANGLE_W+1)'(numer_r);
    hi_sum   = {1'b0, lo_r} + {{(ANGLE_W+1-SECT_BITS){1'b0}}, w_r};
    lo_marg  = {1'b0, lo_r} + {1'b0, marg_r};
    pos_marg = {1'b0, pos_r} + {1'b0, marg_r};
  end

  always_comb begin
    state_nxt      = state_r;
    arc_min_nxt    = arc_min_r;
    arc_max_nxt    = arc_max_r;
    rev_nxt        = rev_r;
    numer_nxt      = numer_r;
    denom_nxt      = denom_r;
    held_nxt       = held_r;
    out_valid_nxt  = out_valid_r;
    pos_nxt        = pos_r;
    w_nxt          = w_r;
    idx_nxt        = idx_r;
    lo_nxt         = lo_r;
    marg_nxt       = marg_r;
    out_notch_nxt  = out_notch_r;
    out_report_nxt = out_report_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    div_nxt        = div_r;
    cnt_nxt        = cnt_r;

    if (cfg_we) begin
      unique case (cfg_index)
        REG_ARC_MIN:     arc_min_nxt = cfg_wdata[ANGLE_W-1:0];
        REG_ARC_MAX:     arc_max_nxt = cfg_wdata[ANGLE_W-1:0];
        REG_REVERSE_DIR: rev_nxt     = cfg_wdata[0];
        REG_HYST_NUMER:  numer_nxt   = cfg_wdata[FRAC_W-1:0];
        REG_HYST_DENOM:  denom_nxt   = cfg_wdata[FRAC_W-1:0];
        default: ;
      endcase
    end

    // A waiting result leaves once the sink takes it.
    if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_chan.bus_error) begin
            state_nxt = ST_FINISH;
          end else if (arc_bad) begin
            // A degenerate arc forces neutral with no hysteresis.
            held_nxt  = NOTCH_NEUTRAL;
            state_nxt = ST_FINISH;
          end else begin
            pos_nxt   = pos_new;
            state_nxt = ST_WIDTH;
          end
        end
      end
      ST_WIDTH: begin
        w_nxt = w_new;
        if (w_new == '0) begin
          // Narrow arc: neutral, with zero sector bounds and zero margin.
          idx_nxt   = NOTCH_NEUTRAL;
          lo_nxt    = '0;
          marg_nxt  = '0;
          state_nxt = ST_DECIDE;
        end else begin
          rem_nxt   = '0;
          quo_nxt   = pos_r;
          div_nxt   = {{(ANGLE_W-SECT_BITS){1'b0}}, w_new};
          cnt_nxt   = '0;
          state_nxt = ST_DIVI;
        end
      end
      ST_DIVI: begin
        rem_nxt = rem_step;
        quo_nxt = quo_step;
        cnt_nxt = cnt_r + 1'b1;
        if (div_last) begin
          cnt_nxt = '0;
          // The top sector also takes the leftover counts at the arc end.
          if (quo_step >= ANGLE_W'(NOTCH_TOP)) begin
            idx_nxt = NOTCH_TOP;
          end else begin
            idx_nxt = quo_step[NOTCH_W-1:0];
          end
          state_nxt = ST_PROD;
        end
      end
      ST_PROD: begin
        lo_nxt = lo_full[ANGLE_W-1:0];
        if (denom_r == '0) begin
          marg_nxt  = '0;
          state_nxt = ST_DECIDE;
        end else begin
          rem_nxt   = '0;
          quo_nxt   = wn_full[ANGLE_W-1:0];
          div_nxt   = {{(ANGLE_W-FRAC_W){1'b0}}, denom_r};
          cnt_nxt   = '0;
          state_nxt = ST_DIVM;
        end
      end
      ST_DIVM: begin
        rem_nxt = rem_step;
        quo_nxt = quo_step;
        cnt_nxt = cnt_r + 1'b1;
        if (div_last) begin
          cnt_nxt   = '0;
          marg_nxt  = quo_step;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        // Moving up needs the position a margin above the sector base; moving down
        // needs it a margin below the sector top.
        if (idx_r > held_r) begin
          if ({1'b0, pos_r} >= lo_marg) begin
            held_nxt = idx_r;
          end
        end else if (idx_r < held_r) begin
          if (pos_marg <= hi_sum) begin
            held_nxt = idx_r;
          end
        end
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt  = 1'b1;
          out_notch_nxt  = held_r;
          out_report_nxt = report_of(held_r);
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      arc_min_r   <= RST_ARC_MIN;
      arc_max_r   <= RST_ARC_MAX;
      rev_r       <= 1'b0;
      numer_r     <= RST_HYST_NUMER;
      denom_r     <= RST_HYST_DENOM;
      held_r      <= NOTCH_NEUTRAL;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      arc_min_r   <= arc_min_nxt;
      arc_max_r   <= arc_max_nxt;
      rev_r       <= rev_nxt;
      numer_r     <= numer_nxt;
      denom_r     <= denom_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    w_r          <= w_nxt;
    idx_r        <= idx_nxt;
    lo_r         <= lo_nxt;
    marg_r       <= marg_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    div_r        <= div_nxt;
    out_notch_r  <= out_notch_nxt;
    out_report_r <= out_report_nxt;
  end

endmodule
